[rtl/nppcs_pkg.sv]
// Shared types, constants and the distance function for the palette color pair search.
package nppcs_pkg;

  localparam int COMP_W  = 16;
  localparam int INDEX_W = 16;
  localparam int DIST_W  = 11;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [DIST_W-1:0]  DIST_INIT      = '1;
  localparam logic [INDEX_W-1:0] FG_START_INDEX = 16'd0;
  localparam logic [INDEX_W-1:0] BG_START_INDEX = 16'd1;

  localparam logic [2:0] REG_FG_RED       = 3'd0;
  localparam logic [2:0] REG_FG_GREEN     = 3'd1;
  localparam logic [2:0] REG_FG_BLUE      = 3'd2;
  localparam logic [2:0] REG_BG_RED       = 3'd3;
  localparam logic [2:0] REG_BG_GREEN     = 3'd4;
  localparam logic [2:0] REG_BG_BLUE      = 3'd5;
  localparam logic [2:0] REG_FG_SEARCH_ON = 3'd6;
  localparam logic [2:0] REG_BG_SEARCH_ON = 3'd7;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } color_t;

  typedef struct packed {
    color_t fg_color;
    color_t bg_color;
    logic   fg_search_on;
    logic   bg_search_on;
  } cfg_t;

  function automatic logic [7:0] absdiff8(input logic [COMP_W-1:0] a,
                                          input logic [COMP_W-1:0] b);
    logic [7:0] x;
    logic [7:0] y;
    x = a[COMP_W-1:COMP_W-8];
    y = b[COMP_W-1:COMP_W-8];
    return (x > y) ? (x - y) : (y - x);
  endfunction

  function automatic logic [DIST_W-1:0] color_distance(input color_t c, input color_t t);
    logic [DIST_W-1:0] dr;
    logic [DIST_W-1:0] dg;
    logic [DIST_W-1:0] db;
    dr = {2'b00, absdiff8(c.red, t.red), 1'b0};
    dg = {1'b0, absdiff8(c.green, t.green), 2'b00};
    db = {3'b000, absdiff8(c.blue, t.blue)};
    return dr + dg + db;
  endfunction

endpackage

[rtl/nearest_palette_color_pair_search.sv]
// Top level of the nearest palette color search for a foreground and background target.
//
// Palette entries arrive on the input channel (in_valid/in_ready), one transaction
// per entry, and are compared against the two target colors held in the APB-style
// register port. Each transaction is captured in an input register; from there the
// distance, compare and best-match update happen in one pass and, for an
// entry marked last, the result is loaded into the output register.
// A result passes the input register and then the output register. One entry is
// accepted every cycle unless a last entry is held back for a waiting result; the
// rate is set by the single update pass each entry makes through the tracker state.
// When the receiver holds out_ready low, a waiting result stalls only a following
// last entry in the input register, and the channel behind it; earlier entries keep flowing.
// Reset clears the valid bits of both pipeline registers, loads the register defaults
// and starts a fresh scan. After each result the scan state returns to its start values.
// The user must write configuration only while no transaction is in flight (not enforced).
module nearest_palette_color_pair_search
  import nppcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COMP_W-1:0]  entry_red,
  input  logic [COMP_W-1:0]  entry_green,
  input  logic [COMP_W-1:0]  entry_blue,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic               entry_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [INDEX_W-1:0] fg_best_index,
  output logic [INDEX_W-1:0] bg_best_index,
  output logic               fg_exact,
  output logic               bg_exact
);

  cfg_t               cfg;
  logic               s1_valid;
  color_t             s1_color;
  logic [INDEX_W-1:0] s1_index;
  logic               s1_last;
  logic               s1_step;
  logic               skip;
  logic               fg_done;
  logic               bg_done;
  logic [INDEX_W-1:0] fg_result_index;
  logic [INDEX_W-1:0] bg_result_index;
  logic               fg_result_exact;
  logic               bg_result_exact;

  nppcs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s1_step  = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_step;
  assign skip     = fg_done && bg_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_color.red   <= entry_red;
      s1_color.green <= entry_green;
      s1_color.blue  <= entry_blue;
      s1_index       <= entry_index;
      s1_last        <= entry_last;
    end
  end

  nppcs_track u_fg_track (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_step),
    .last         (s1_last),
    .skip         (skip),
    .search_on    (cfg.fg_search_on),
    .start_index  (FG_START_INDEX),
    .target       (cfg.fg_color),
    .entry        (s1_color),
    .entry_index  (s1_index),
    .done         (fg_done),
    .result_index (fg_result_index),
    .result_exact (fg_result_exact)
  );

  nppcs_track u_bg_track (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_step),
    .last         (s1_last),
    .skip         (skip),
    .search_on    (cfg.bg_search_on),
    .start_index  (BG_START_INDEX),
    .target       (cfg.bg_color),
    .entry        (s1_color),
    .entry_index  (s1_index),
    .done         (bg_done),
    .result_index (bg_result_index),
    .result_exact (bg_result_exact)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_step && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && s1_last) begin
      fg_best_index <= fg_result_index;
      bg_best_index <= bg_result_index;
      fg_exact      <= fg_result_exact;
      bg_exact      <= bg_result_exact;
    end
  end

endmodule

[rtl/nppcs_regs.sv]
// Configuration register file with its APB-style access port.
module nppcs_regs
  import nppcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_color     <= '0;
      cfg.bg_color     <= '0;
      cfg.fg_search_on <= 1'b1;
      cfg.bg_search_on <= 1'b1;
    end else if (wr_en) begin
      case (reg_sel)
        REG_FG_RED:       cfg.fg_color.red   <= pwdata[COMP_W-1:0];
        REG_FG_GREEN:     cfg.fg_color.green <= pwdata[COMP_W-1:0];
        REG_FG_BLUE:      cfg.fg_color.blue  <= pwdata[COMP_W-1:0];
        REG_BG_RED:       cfg.bg_color.red   <= pwdata[COMP_W-1:0];
        REG_BG_GREEN:     cfg.bg_color.green <= pwdata[COMP_W-1:0];
        REG_BG_BLUE:      cfg.bg_color.blue  <= pwdata[COMP_W-1:0];
        REG_FG_SEARCH_ON: cfg.fg_search_on   <= pwdata[0];
        REG_BG_SEARCH_ON: cfg.bg_search_on   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_FG_RED:       prdata[COMP_W-1:0] = cfg.fg_color.red;
      REG_FG_GREEN:     prdata[COMP_W-1:0] = cfg.fg_color.green;
      REG_FG_BLUE:      prdata[COMP_W-1:0] = cfg.fg_color.blue;
      REG_BG_RED:       prdata[COMP_W-1:0] = cfg.bg_color.red;
      REG_BG_GREEN:     prdata[COMP_W-1:0] = cfg.bg_color.green;
      REG_BG_BLUE:      prdata[COMP_W-1:0] = cfg.bg_color.blue;
      REG_FG_SEARCH_ON: prdata[0]          = cfg.fg_search_on;
      REG_BG_SEARCH_ON: prdata[0]          = cfg.bg_search_on;
      default:          prdata             = '0;
    endcase
  end

endmodule

[rtl/nppcs_track.sv]
// Best-match tracker for one target color across one palette scan.
module nppcs_track
  import nppcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               last,
  input  logic               skip,
  input  logic               search_on,
  input  logic [INDEX_W-1:0] start_index,
  input  color_t             target,
  input  color_t             entry,
  input  logic [INDEX_W-1:0] entry_index,
  output logic               done,
  output logic [INDEX_W-1:0] result_index,
  output logic               result_exact
);

  logic [DIST_W-1:0]  best_distance;
  logic [INDEX_W-1:0] best_index;
  logic               found;
  logic [DIST_W-1:0]  entry_distance;
  logic               update;
  logic               found_next;

  assign done           = found || !search_on;
  assign entry_distance = color_distance(entry, target);
  assign update         = !skip && !done && (entry_distance < best_distance);
  assign found_next     = found || (update && (entry_distance == '0));
  assign result_index   = update ? entry_index : best_index;
  assign result_exact   = found_next || !search_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance <= DIST_INIT;
      best_index    <= start_index;
      found         <= 1'b0;
    end else if (step) begin
      if (last) begin
        best_distance <= DIST_INIT;
        best_index    <= start_index;
        found         <= 1'b0;
      end else if (update) begin
        best_distance <= entry_distance;
        best_index    <= entry_index;
        found         <= found_next;
      end
    end
  end

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the nearest palette color pair search block.
module tb_top
  import nppcs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 46;

  typedef struct {
    logic [COMP_W-1:0]  red;
    logic [COMP_W-1:0]  green;
    logic [COMP_W-1:0]  blue;
    logic [INDEX_W-1:0] index;
    logic               last;
  } palette_entry_t;

  typedef struct {
    logic [INDEX_W-1:0] fg_index;
    logic [INDEX_W-1:0] bg_index;
    logic               fg_exact;
    logic               bg_exact;
  } match_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [COMP_W-1:0]  entry_red = '0;
  logic [COMP_W-1:0]  entry_green = '0;
  logic [COMP_W-1:0]  entry_blue = '0;
  logic [INDEX_W-1:0] entry_index = '0;
  logic               entry_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [INDEX_W-1:0] fg_best_index;
  logic [INDEX_W-1:0] bg_best_index;
  logic               fg_exact;
  logic               bg_exact;

  color_t             fg_target = '0;
  color_t             bg_target = '0;
  logic               fg_enable = 1'b1;
  logic               bg_enable = 1'b1;
  logic [DIST_W-1:0]  fg_min_dist = DIST_INIT;
  logic [DIST_W-1:0]  bg_min_dist = DIST_INIT;
  logic [INDEX_W-1:0] fg_pick = FG_START_INDEX;
  logic [INDEX_W-1:0] bg_pick = BG_START_INDEX;
  logic               fg_hit = 1'b0;
  logic               bg_hit = 1'b0;

  palette_entry_t     pending_entries[$];
  match_result_t      awaited_matches[$];
  palette_entry_t     driven_entry;
  int                 gap_left = 0;
  int                 stall_left = 0;
  int                 error_count = 0;
  int                 cycle_count = 0;
  logic               no_idle = 1'b0;

  nearest_palette_color_pair_search u_top (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .entry_red     (entry_red),
    .entry_green   (entry_green),
    .entry_blue    (entry_blue),
    .entry_index   (entry_index),
    .entry_last    (entry_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .fg_best_index (fg_best_index),
    .bg_best_index (bg_best_index),
    .fg_exact      (fg_exact),
    .bg_exact      (bg_exact)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] upper_gap(input logic [COMP_W-1:0] a,
                                           input logic [COMP_W-1:0] b);
    logic [7:0] ha;
    logic [7:0] hb;
    ha = a[COMP_W-1 -: 8];
    hb = b[COMP_W-1 -: 8];
    if (ha >= hb) return ha - hb;
    return hb - ha;
  endfunction

  function automatic logic [DIST_W-1:0] weighted_distance(input color_t c, input color_t t);
    logic [DIST_W-1:0] sum;
    sum = DIST_W'(upper_gap(c.red, t.red)) << 1;
    sum = sum + (DIST_W'(upper_gap(c.green, t.green)) << 2);
    sum = sum + DIST_W'(upper_gap(c.blue, t.blue));
    return sum;
  endfunction

  task automatic start_new_scan();
    fg_min_dist = DIST_INIT;
    bg_min_dist = DIST_INIT;
    fg_pick     = FG_START_INDEX;
    bg_pick     = BG_START_INDEX;
    fg_hit      = 1'b0;
    bg_hit      = 1'b0;
  endtask

  task automatic track_entry(input palette_entry_t e);
    color_t            c;
    logic [DIST_W-1:0] d;
    logic              fg_done;
    logic              bg_done;
    match_result_t     r;
    c.red   = e.red;
    c.green = e.green;
    c.blue  = e.blue;
    fg_done = fg_hit || !fg_enable;
    bg_done = bg_hit || !bg_enable;
    if (!fg_done) begin
      d = weighted_distance(c, fg_target);
      if (d < fg_min_dist) begin
        fg_min_dist = d;
        fg_pick     = e.index;
        if (d == '0) fg_hit = 1'b1;
      end
    end
    if (!bg_done) begin
      d = weighted_distance(c, bg_target);
      if (d < bg_min_dist) begin
        bg_min_dist = d;
        bg_pick     = e.index;
        if (d == '0) bg_hit = 1'b1;
      end
    end
    if (e.last) begin
      r.fg_index = fg_pick;
      r.bg_index = bg_pick;
      r.fg_exact = fg_hit || !fg_enable;
      r.bg_exact = bg_hit || !bg_enable;
      awaited_matches.push_back(r);
      start_new_scan();
    end
  endtask

  function automatic int pick_delay();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void check_field(input string name, input logic [INDEX_W-1:0] want,
                                      input logic [INDEX_W-1:0] got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) track_entry(driven_entry);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_entries.size() > 0) begin
          driven_entry = pending_entries.pop_front();
          entry_red   <= driven_entry.red;
          entry_green <= driven_entry.green;
          entry_blue  <= driven_entry.blue;
          entry_index <= driven_entry.index;
          entry_last  <= driven_entry.last;
          in_valid    <= 1'b1;
          gap_left = pick_delay();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    match_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_matches.size() == 0) begin
          $display("%0t: result transaction with none expected, actual %h %h %b %b", $time,
                   fg_best_index, bg_best_index, fg_exact, bg_exact);
          error_count++;
        end else begin
          want = awaited_matches.pop_front();
          check_field("fg_best_index", want.fg_index, fg_best_index);
          check_field("bg_best_index", want.bg_index, bg_best_index);
          check_field("fg_exact", INDEX_W'(want.fg_exact), INDEX_W'(fg_exact));
          check_field("bg_exact", INDEX_W'(want.bg_exact), INDEX_W'(bg_exact));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_delay();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic write_register(input logic [2:0] sel, input logic [15:0] value);
    logic [DATA_W-1:0] word;
    word = {16'($urandom_range(0, 65535)), value};
    if (sel == REG_FG_SEARCH_ON || sel == REG_BG_SEARCH_ON)
      word[DATA_W-1:1] = (DATA_W-1)'($urandom);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({sel, 2'b00});
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_FG_RED:       fg_target.red   = word[15:0];
      REG_FG_GREEN:     fg_target.green = word[15:0];
      REG_FG_BLUE:      fg_target.blue  = word[15:0];
      REG_BG_RED:       bg_target.red   = word[15:0];
      REG_BG_GREEN:     bg_target.green = word[15:0];
      REG_BG_BLUE:      bg_target.blue  = word[15:0];
      REG_FG_SEARCH_ON: fg_enable       = word[0];
      REG_BG_SEARCH_ON: bg_enable       = word[0];
      default: ;
    endcase
  endtask

  task automatic set_targets(input color_t fg, input color_t bg,
                             input logic fg_on, input logic bg_on);
    write_register(REG_FG_RED, fg.red);
    write_register(REG_FG_GREEN, fg.green);
    write_register(REG_FG_BLUE, fg.blue);
    write_register(REG_BG_RED, bg.red);
    write_register(REG_BG_GREEN, bg.green);
    write_register(REG_BG_BLUE, bg.blue);
    write_register(REG_FG_SEARCH_ON, {15'd0, fg_on});
    write_register(REG_BG_SEARCH_ON, {15'd0, bg_on});
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_entries.size() != 0 || in_valid || awaited_matches.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_entry(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b,
                            input logic [15:0] idx, input logic last);
    palette_entry_t e;
    e.red   = r;
    e.green = g;
    e.blue  = b;
    e.index = idx;
    e.last  = last;
    pending_entries.push_back(e);
  endtask

  function automatic logic [15:0] random_component();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic color_t random_color();
    color_t c;
    c.red   = random_component();
    c.green = random_component();
    c.blue  = random_component();
    return c;
  endfunction

  function automatic logic [15:0] jitter(input logic [15:0] t, input int spread);
    logic [7:0] hi;
    hi = t[15:8] + 8'($urandom_range(0, 2 * spread)) - 8'(spread);
    return {hi, 8'($urandom_range(0, 255))};
  endfunction

  function automatic palette_entry_t random_entry(input logic last);
    palette_entry_t e;
    color_t         base;
    int             spread;
    int             mode;
    mode   = $urandom_range(0, 9);
    base   = ($urandom_range(0, 1) == 0) ? fg_target : bg_target;
    spread = (mode < 4) ? 0 : 2;
    if (mode < 6) begin
      if (mode < 2) base = fg_target;
      else if (mode < 4) base = bg_target;
      e.red   = jitter(base.red, spread);
      e.green = jitter(base.green, spread);
      e.blue  = jitter(base.blue, spread);
    end else if (mode == 6) begin
      e.red   = random_component();
      e.green = random_component();
      e.blue  = random_component();
    end else begin
      e.red   = 16'($urandom_range(0, 65535));
      e.green = 16'($urandom_range(0, 65535));
      e.blue  = 16'($urandom_range(0, 65535));
    end
    case ($urandom_range(0, 9))
      0: e.index = 16'h0000;
      1: e.index = 16'hFFFF;
      default: e.index = 16'($urandom_range(0, 65535));
    endcase
    e.last = last;
    return e;
  endfunction

  initial begin
    int     phase;
    int     count;
    int     len;
    int     sel;
    color_t fg;
    color_t bg;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Both targets black: max distance, a tie, an exact hit, then ignored entries.
    push_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0005, 1'b0);
    push_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0006, 1'b0);
    push_entry(16'h00FF, 16'h00FF, 16'h00FF, 16'h0007, 1'b0);
    push_entry(16'h0000, 16'h0000, 16'h0000, 16'h0008, 1'b0);
    push_entry(16'h1234, 16'h5678, 16'h9ABC, 16'h0009, 1'b1);
    push_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_entry(16'h0100, 16'h0000, 16'h0000, 16'h0010, 1'b0);
    push_entry(16'h0000, 16'h0000, 16'h0100, 16'h0020, 1'b0);
    push_entry(16'h0000, 16'h0100, 16'h0000, 16'h0030, 1'b1);
    wait_idle();

    fg = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    bg = '0;
    set_targets(fg, bg, 1'b1, 1'b0);
    push_entry(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    push_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hABCD, 1'b0);
    push_entry(16'h8000, 16'h8000, 16'h8000, 16'h0001, 1'b1);
    push_entry(16'h8000, 16'h0000, 16'hFF00, 16'h0003, 1'b1);
    wait_idle();

    fg = '{16'h1234, 16'h5678, 16'h9ABC};
    bg = '{16'h8000, 16'h4000, 16'h2000};
    set_targets(fg, bg, 1'b0, 1'b1);
    push_entry(16'h80FF, 16'h40FF, 16'h20FF, 16'h00FF, 1'b0);
    push_entry(16'h0000, 16'h0000, 16'h0000, 16'h0002, 1'b1);
    wait_idle();
    write_register(REG_BG_SEARCH_ON, 16'd0);
    push_entry(16'h5555, 16'hAAAA, 16'h5555, 16'h0007, 1'b1);
    wait_idle();

    // Enables changed in the middle of a scan.
    write_register(REG_FG_SEARCH_ON, 16'd1);
    push_entry(16'h1200, 16'h5600, 16'h9A00, 16'h4444, 1'b0);
    wait_idle();
    write_register(REG_BG_SEARCH_ON, 16'd1);
    push_entry(16'h8000, 16'h4000, 16'h2000, 16'h5555, 1'b1);
    push_entry(16'h0000, 16'h0000, 16'h0000, 16'h0101, 1'b0);
    wait_idle();
    write_register(REG_FG_SEARCH_ON, 16'd0);
    push_entry(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0202, 1'b1);
    wait_idle();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      no_idle = (phase % 3 == 2);
      sel = $urandom_range(0, 7);
      set_targets(random_color(), random_color(), sel != 0 && sel != 2, sel != 1 && sel != 2);
      count = 0;
      while (count < PHASE_ITEMS) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) pending_entries.push_back(random_entry(k == len - 1));
        count += len;
      end
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 3)) pending_entries.push_back(random_entry(1'b0));
      wait_idle();
    end

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
